// File: rtl/core/tshe_pkg.sv
// Shared types and constants for the track speed and heading estimator.
package tshe_pkg;

    localparam int unsigned CordicSteps = 16;
    localparam logic [14:0] FullTurnOut = 15'd23040;
    localparam logic [23:0] FullTurnFine = 24'd5898240;
    localparam logic [23:0] HalfTurnFine = 24'd2949120;
    localparam logic [19:0] SlowSpeed = 20'd256;
    localparam logic [9:0] MsPerS = 10'd1000;

    localparam logic [1:0] CFG_LOCK_SPEED = 2'd0;
    localparam logic [1:0] CFG_CONVERGE = 2'd1;
    localparam logic [1:0] CFG_MIN_BOX = 2'd2;
    localparam logic [1:0] CFG_INIT_HEADING = 2'd3;

    localparam logic OP_OPEN = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_CORDIC,
        ST_MULT,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } unit_ctl_t;

    function automatic logic [23:0] atan_entry(input logic [3:0] idx);
        logic [23:0] r;
        begin
            unique case (idx)
                4'd0: r = 24'd737280;
                4'd1: r = 24'd435242;
                4'd2: r = 24'd229970;
                4'd3: r = 24'd116736;
                4'd4: r = 24'd58595;
                4'd5: r = 24'd29326;
                4'd6: r = 24'd14667;
                4'd7: r = 24'd7334;
                4'd8: r = 24'd3667;
                4'd9: r = 24'd1833;
                4'd10: r = 24'd917;
                4'd11: r = 24'd458;
                4'd12: r = 24'd229;
                4'd13: r = 24'd115;
                4'd14: r = 24'd57;
                default: r = 24'd29;
            endcase
            return r;
        end
    endfunction

    function automatic logic [14:0] wrap_heading(input logic [14:0] h);
        return (h >= FullTurnOut) ? h - FullTurnOut : h;
    endfunction

endpackage

// File: rtl/core/tshe_isqrt.sv
// Bit-pair serial integer square root, two radicand bits per cycle.
module tshe_isqrt import tshe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [39:0] radicand,
    output logic        done,
    output logic [19:0] root
);
    logic [39:0] rad_reg, rad_next;
    logic [21:0] rem_reg, rem_next;
    logic [19:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [21:0] trial;

    always_comb begin
        trial = {rem_reg[19:0], rad_reg[39:38]} - {root_reg, 2'b01};
        rad_next = rad_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next = radicand;
            rem_next = '0;
            root_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[37:0], 2'b00};
            if (!trial[21]) begin
                rem_next = trial;
                root_next = {root_reg[18:0], 1'b1};
            end else begin
                rem_next = {rem_reg[19:0], rad_reg[39:38]};
                root_next = {root_reg[18:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd19) begin
                busy_next = 1'b0;
            end
        end
        if (busy_reg && cnt_reg == 5'd19 && !start) begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// File: rtl/core/tshe_cordic.sv
// Iterative vectoring CORDIC giving the north-referenced heading.
module tshe_cordic import tshe_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [19:0] vel_x,
    input  logic signed [19:0] vel_y,
    output logic               done,
    output logic [14:0]        heading
);
    logic signed [31:0] a_reg, a_next, b_reg, b_next;
    logic signed [25:0] z_reg, z_next;
    logic [3:0]  i_reg, i_next;
    logic        busy_reg, busy_next;
    logic        zero_reg, zero_next;
    logic        done_reg, done_next;
    logic signed [31:0] a_sh, b_sh;
    logic signed [25:0] zw, zr;
    logic [25:0] zr_u;
    logic [17:0] rnd;

    always_comb begin
        a_sh = a_reg >>> i_reg;
        b_sh = b_reg >>> i_reg;
        a_next = a_reg;
        b_next = b_reg;
        z_next = z_reg;
        i_next = i_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        if (start) begin
            zero_next = (vel_x == '0) && (vel_y == '0);
            if (vel_y < 0) begin
                a_next = -({{4{vel_y[19]}}, vel_y, 8'd0});
                b_next = -({{4{vel_x[19]}}, vel_x, 8'd0});
                z_next = 26'(HalfTurnFine);
            end else begin
                a_next = {{4{vel_y[19]}}, vel_y, 8'd0};
                b_next = {{4{vel_x[19]}}, vel_x, 8'd0};
                z_next = '0;
            end
            i_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg > 0) begin
                a_next = a_reg + b_sh;
                b_next = b_reg - a_sh;
                z_next = z_reg + $signed({2'b00, atan_entry(i_reg)});
            end else begin
                a_next = a_reg - b_sh;
                b_next = b_reg + a_sh;
                z_next = z_reg - $signed({2'b00, atan_entry(i_reg)});
            end
            i_next = i_reg + 4'd1;
            if (i_reg == 4'(CordicSteps - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb begin
        zw = z_reg;
        if (zw < 0) begin
            zw = zw + $signed({2'b00, FullTurnFine});
        end else if (zw >= $signed({2'b00, FullTurnFine})) begin
            zw = zw - $signed({2'b00, FullTurnFine});
        end
        zr = zw + 26'sd128;
        zr_u = zr;
        rnd = zr_u[25:8];
        if (zero_reg) begin
            heading = '0;
        end else if (rnd >= {3'd0, FullTurnOut}) begin
            heading = 15'(rnd - {3'd0, FullTurnOut});
        end else begin
            heading = rnd[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            i_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            i_reg <= i_next;
            done_reg <= done_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        z_reg <= z_next;
        zero_reg <= zero_next;
    end

    assign done = done_reg;
endmodule

// File: rtl/core/tshe_divider.sv
// Restoring divider, one quotient bit per cycle, for the acceleration.
module tshe_divider import tshe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [29:0] dividend,
    input  logic [47:0] divisor,
    output logic        done,
    output logic [29:0] quotient
);
    logic [29:0] q_reg, q_next;
    logic [48:0] r_reg, r_next;
    logic [47:0] d_reg, d_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [48:0] sh, diff;

    always_comb begin
        sh = {r_reg[47:0], q_reg[29]};
        diff = sh - {1'b0, d_reg};
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[48]) begin
                r_next = diff;
                q_next = {q_reg[28:0], 1'b1};
            end else begin
                r_next = sh;
                q_next = {q_reg[28:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd29) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quotient = q_reg;
endmodule

// File: rtl/core/track_speed_heading_estimator.sv
// Top level of the track speed and heading estimator.
// One item at a time. An open item (op 0) loads the track state and gives no
// result. A frame item gives its result after these steps in order: the squares,
// the bit-pair square root, the 16 CORDIC iterations (the scaling multiply runs
// alongside), the bit-serial acceleration divider and the load of the result
// register. The input is ready again in the cycle after the result transfers.
module track_speed_heading_estimator import tshe_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // lsb up: vel_x, vel_y, var_vx, var_vy, box_height, lane_dir, time_ms, pad
    input  logic [167:0] s_tdata,
    input  logic         s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    // lsb up: speed, heading, accel, speed_confident, pad
    output logic [63:0]  m_tdata
);
    state_t state_reg, state_next;
    unit_ctl_t ctl;

    logic [19:0] lock_reg;
    logic [23:0] conv_reg;
    logic [11:0] minbox_reg;
    logic [14:0] inith_cfg_reg;

    logic [14:0] prev_heading_reg, init_heading_reg;
    logic [19:0] prev_speed_reg;
    logic [47:0] prev_time_reg;

    logic signed [19:0] vx_reg, vy_reg;
    logic [24:0] varsum_reg;
    logic [11:0] box_reg;
    logic [14:0] link_reg;
    logic [47:0] now_reg;
    logic [39:0] sq_reg;
    logic [19:0] speed_reg;
    logic [14:0] head_reg;
    logic [29:0] mag_reg;
    logic        neg_reg;
    logic        mult_phase_reg;

    logic [63:0] out_reg;
    logic        out_valid_reg;

    logic        accept, open_go;
    logic signed [19:0] in_vx, in_vy;
    logic [14:0] in_link;
    logic        sq_start, sq_done, cd_start, cd_done, dv_start, dv_done;
    logic [19:0] sq_root;
    logic [14:0] cd_head;
    logic [29:0] dv_q;
    logic        conf, tall;
    logic [47:0] dt;
    logic [20:0] sdiff;
    logic [14:0] heading_sel;
    logic signed [23:0] acc;
    logic [39:0] sq_x, sq_y;

    assign in_vx = s_tdata[19:0];
    assign in_vy = s_tdata[39:20];
    assign in_link = wrap_heading(s_tdata[114:100]);

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept = s_tvalid && s_tready;
    assign open_go = accept && (s_tuser == OP_OPEN);

    assign conf = varsum_reg < {conv_reg, 1'b0};
    assign tall = box_reg >= minbox_reg;
    assign dt = now_reg - prev_time_reg;
    assign sdiff = {1'b0, speed_reg} - {1'b0, prev_speed_reg};
    assign sq_x = 40'($signed(vx_reg) * $signed(vx_reg));
    assign sq_y = 40'($signed(vy_reg) * $signed(vy_reg));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept && s_tuser == OP_EVAL) state_next = ST_MULT;
            ST_MULT:   if (mult_phase_reg) state_next = ST_SQRT;
            ST_SQRT:   if (sq_done) state_next = ST_CORDIC;
            ST_CORDIC: if (cd_done) state_next = ST_DIV;
            ST_DIV:    if (dv_done) state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        unique case (state_reg)
            ST_MULT:   ctl.start = mult_phase_reg;
            ST_SQRT:   ctl.busy = 1'b1;
            ST_CORDIC: ctl.busy = 1'b1;
            ST_DIV:    ctl.busy = 1'b1;
            ST_DONE:   ctl.done = 1'b1;
            default:   ctl = '0;
        endcase
    end

    assign sq_start = ctl.start;
    assign cd_start = (state_reg == ST_SQRT) && sq_done;
    assign dv_start = (state_reg == ST_CORDIC) && cd_done;

    always_comb begin
        if (conf && tall && speed_reg > lock_reg) begin
            heading_sel = head_reg;
        end else if (speed_reg > SlowSpeed) begin
            heading_sel = prev_heading_reg;
        end else if (link_reg != '0) begin
            heading_sel = link_reg;
        end else begin
            heading_sel = init_heading_reg;
        end
        acc = '0;
        if (conf && dt != '0) begin
            if (neg_reg) begin
                acc = (dv_q > 30'd8388608) ? 24'sh800000 : 24'(-$signed({1'b0, dv_q}));
            end else begin
                acc = (dv_q > 30'd8388607) ? 24'sh7fffff : 24'(dv_q);
            end
        end
    end

    tshe_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start), .radicand(sq_reg),
        .done(sq_done), .root(sq_root)
    );

    tshe_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cd_start), .vel_x(vx_reg),
        .vel_y(vy_reg), .done(cd_done), .heading(cd_head)
    );

    tshe_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start), .dividend(mag_reg),
        .divisor((dt == '0) ? 48'd1 : dt), .done(dv_done), .quotient(dv_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mult_phase_reg <= 1'b0;
            lock_reg <= 20'd512;
            conv_reg <= 24'd256;
            minbox_reg <= 12'd20;
            inith_cfg_reg <= '0;
            prev_heading_reg <= '0;
            prev_speed_reg <= '0;
            prev_time_reg <= '0;
            init_heading_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_LOCK_SPEED:   lock_reg <= cfg_data[19:0];
                    CFG_CONVERGE:     conv_reg <= cfg_data;
                    CFG_MIN_BOX:      minbox_reg <= cfg_data[11:0];
                    CFG_INIT_HEADING: inith_cfg_reg <= cfg_data[14:0];
                    default:          lock_reg <= lock_reg;
                endcase
            end
            mult_phase_reg <= (state_reg == ST_MULT) && !mult_phase_reg;
            if (open_go) begin
                init_heading_reg <= (in_link != '0) ? in_link : wrap_heading(inith_cfg_reg);
                prev_heading_reg <= (in_link != '0) ? in_link : wrap_heading(inith_cfg_reg);
                prev_speed_reg <= '0;
                prev_time_reg <= s_tdata[162:115];
            end
            if (ctl.done) begin
                prev_heading_reg <= heading_sel;
                prev_speed_reg <= speed_reg;
                prev_time_reg <= now_reg;
                out_valid_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            vx_reg <= in_vx;
            vy_reg <= in_vy;
            varsum_reg <= {1'b0, s_tdata[63:40]} + {1'b0, s_tdata[87:64]};
            box_reg <= s_tdata[99:88];
            link_reg <= in_link;
            now_reg <= s_tdata[162:115];
        end
        if (state_reg == ST_MULT && !mult_phase_reg) begin
            sq_reg <= sq_x + sq_y;
        end
        if (sq_done) begin
            speed_reg <= sq_root;
        end
        if (cd_done) begin
            head_reg <= cd_head;
        end
        if (state_reg == ST_CORDIC) begin
            neg_reg <= sdiff[20];
            mag_reg <= 30'((sdiff[20] ? 20'(-sdiff) : sdiff[19:0]) * MsPerS);
        end
        if (ctl.done) begin
            out_reg <= {3'd0, 1'b0, conf, acc, heading_sel, speed_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == ST_IDLE)) else $error("ready while busy");
    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !s_tready) else $error("accept with result pending");
    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.done |=> m_tvalid) else $error("result lost");
`endif
endmodule

// File: test/tb_track_speed_heading_estimator.sv
// Testbench for the track speed and heading estimator: directed table plus random frames.
`timescale 1ns / 100ps

module tb_track_speed_heading_estimator;
    import tshe_pkg::*;

    typedef struct {
        logic               op;
        logic signed [19:0] vx;
        logic signed [19:0] vy;
        logic [23:0]        varx;
        logic [23:0]        vary;
        logic [11:0]        box;
        logic [14:0]        link;
        logic [47:0]        tms;
    } track_item_t;

    typedef struct {
        logic [19:0] speed;
        logic [14:0] heading;
        logic [23:0] accel;
        logic        conf;
    } track_est_t;

    typedef struct {
        track_item_t itm;
        bit          typed;
        track_est_t  est;
    } dir_row_t;

    localparam int IdleLimit = 20000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [23:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;

    track_speed_heading_estimator dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state and register copies
    logic [19:0] lock_spd = 20'd512;
    logic [23:0] conv_thr = 24'd256;
    logic [11:0] min_box = 12'd20;
    logic [14:0] init_cfg = 15'd0;
    logic [14:0] last_head = '0;
    logic [19:0] last_speed = '0;
    logic [14:0] track_head = '0;
    logic [47:0] last_time = '0;

    track_est_t est_q[$];
    int  errs = 0;
    int  idle_cnt = 0;
    int  snd_idle = 28;
    int  rcv_idle = 75;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_cnt = 0;
    logic [47:0] gen_time = '0;

    localparam longint AtanTab[16] = '{737280, 435242, 229970, 116736, 58595, 29326,
        14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

    function automatic logic [14:0] fold_turn(logic [14:0] h);
        return (h >= 15'd23040) ? h - 15'd23040 : h;
    endfunction

    function automatic logic [19:0] root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 40;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r[19:0];
    endfunction

    function automatic logic [14:0] north_dir(longint e, longint n);
        longint a, b, z, base, t;
        if (e == 0 && n == 0) return '0;
        a = n * 256;
        b = e * 256;
        z = 0;
        base = 0;
        if (a < 0) begin
            a = -a;
            b = -b;
            base = 2949120;
        end
        for (int i = 0; i < 16; i++) begin
            if (b > 0) begin
                t = a + (b >>> i);
                b = b - (a >>> i);
                z += AtanTab[i];
            end else begin
                t = a - (b >>> i);
                b = b + (a >>> i);
                z -= AtanTab[i];
            end
            a = t;
        end
        z += base;
        while (z < 0) z += 5898240;
        while (z >= 5898240) z -= 5898240;
        t = (z + 128) >>> 8;
        if (t >= 23040) t -= 23040;
        return t[14:0];
    endfunction

    // updates track state; returns 1 when the item yields an estimate
    function automatic bit estimate(track_item_t it, output track_est_t r);
        longint vx, vy, diff, acc;
        longint unsigned mag;
        logic [47:0] dt;
        logic [14:0] lnk, hd;
        logic [19:0] spd;
        bit conf, tall;
        vx = it.vx;
        vy = it.vy;
        lnk = fold_turn(it.link);
        r = '{default: '0};
        if (it.op == OP_OPEN) begin
            track_head = (lnk != 0) ? lnk : fold_turn(init_cfg);
            last_head = track_head;
            last_speed = '0;
            last_time = it.tms;
            return 0;
        end
        spd = root_floor(longint'(vx * vx + vy * vy));
        conf = (longint'(it.varx) + longint'(it.vary)) < 2 * longint'(conv_thr);
        tall = it.box >= min_box;
        if (conf && tall && spd > lock_spd) hd = north_dir(vx, vy);
        else if (spd > 20'd256) hd = last_head;
        else hd = (lnk != 0) ? lnk : track_head;
        dt = it.tms - last_time;
        acc = 0;
        if (conf && dt != 0) begin
            diff = longint'(spd) - longint'(last_speed);
            mag = longint'(diff < 0 ? -diff : diff) * 1000 / longint'(dt);
            if (diff < 0) acc = (mag > 8388608) ? -8388608 : -longint'(mag);
            else acc = (mag > 8388607) ? 8388607 : longint'(mag);
        end
        last_head = hd;
        last_speed = spd;
        last_time = it.tms;
        r.speed = spd;
        r.heading = hd;
        r.accel = acc[23:0];
        r.conf = conf;
        return 1;
    endfunction

    task automatic send_item(track_item_t it, bit typed, track_est_t typed_est);
        track_est_t r;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {5'b0, it.tms, it.link, it.box, it.vary, it.varx, it.vy, it.vx};
        do @(posedge aclk); while (!s_tready);
        if (estimate(it, r)) est_q.insert(est_q.size(), typed ? typed_est : r);
        if ($urandom_range(0, 99) < snd_idle) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
        end
    endtask

    task automatic settle_and_write(logic [19:0] ls, logic [23:0] ct, logic [11:0] mb,
                                    logic [14:0] ih);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (est_q.size() == 0);
        repeat (100) @(posedge aclk);
        @(negedge aclk);
        cfg_we <= 1'b1; cfg_index <= CFG_LOCK_SPEED; cfg_data <= 24'(ls);
        @(negedge aclk);
        cfg_index <= CFG_CONVERGE; cfg_data <= ct;
        @(negedge aclk);
        cfg_index <= CFG_MIN_BOX; cfg_data <= 24'(mb);
        @(negedge aclk);
        cfg_index <= CFG_INIT_HEADING; cfg_data <= 24'(ih);
        @(negedge aclk);
        cfg_we <= 1'b0;
        lock_spd = ls; conv_thr = ct; min_box = mb; init_cfg = ih;
    endtask

    function automatic logic signed [19:0] rand_vel();
        case ($urandom_range(0, 4))
            0: return 20'($urandom);
            1: return 20'($signed($urandom_range(0, 1200)) - 600);
            2: return 20'($signed($urandom_range(0, 8000)) - 4000);
            3: return $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
            default: return 20'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    function automatic logic [23:0] rand_var();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 32'(conv_thr)));
            default: return 24'($urandom_range(0, 32'(conv_thr) + 64));
        endcase
    endfunction

    function automatic track_item_t rand_item();
        track_item_t it;
        it.op = ($urandom_range(0, 99) < 8) ? OP_OPEN : OP_EVAL;
        it.vx = rand_vel();
        it.vy = rand_vel();
        it.varx = rand_var();
        it.vary = rand_var();
        it.box = $urandom_range(0, 3) == 0 ? 12'($urandom)
                                           : 12'($urandom_range(0, 32'(min_box) + 8));
        it.link = $urandom_range(0, 1) ? 15'd0 : 15'($urandom);
        case ($urandom_range(0, 9))
            0: gen_time = {16'($urandom), 32'($urandom)};
            1: ;
            default: gen_time = gen_time + 48'($urandom_range(1, 200));
        endcase
        it.tms = gen_time;
        return it;
    endfunction

    task automatic run_random(int n, bit pause_mid, bit hold_mid);
        track_est_t none;
        none = '{default: '0};
        for (int i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                wait (est_q.size() == 0);
            end
            if (hold_mid && i == n / 2) hold_req++;
            send_item(rand_item(), 0, none);
        end
    endtask

    function automatic dir_row_t row(logic op, int vx, int vy, int vrx, int vry, int bx,
                                     int lk, longint t);
        dir_row_t d;
        d.itm = '{op, 20'(vx), 20'(vy), 24'(vrx), 24'(vry), 12'(bx), 15'(lk), 48'(t)};
        d.typed = 0;
        d.est = '{default: '0};
        return d;
    endfunction

    // receiver: random ready, long hold-offs on request
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_cnt = 600;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    always @(posedge aclk) begin
        track_est_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IdleLimit) begin
            $display("Mismatches found");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (est_q.size() == 0) begin
                errs++;
                $display("%0t: unexpected transfer, actual %h", $realtime, m_tdata);
            end else begin
                want = est_q.pop_front();
                if (m_tdata[19:0] !== want.speed) begin
                    errs++;
                    $display("%0t: speed expected %0d actual %0d", $realtime, want.speed,
                             m_tdata[19:0]);
                end
                if (m_tdata[34:20] !== want.heading) begin
                    errs++;
                    $display("%0t: heading expected %0d actual %0d", $realtime,
                             want.heading, m_tdata[34:20]);
                end
                if (m_tdata[58:35] !== want.accel) begin
                    errs++;
                    $display("%0t: accel expected %0d actual %0d", $realtime,
                             $signed(want.accel), $signed(m_tdata[58:35]));
                end
                if (m_tdata[59] !== want.conf) begin
                    errs++;
                    $display("%0t: confident expected %0b actual %0b", $realtime,
                             want.conf, m_tdata[59]);
                end
            end
        end
    end

    initial begin
        dir_row_t tab[$];
        dir_row_t d;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // frame before any open, standing still: reset state gives zero speed, heading and accel, confident set
        d = row(OP_EVAL, 0, 0, 0, 0, 0, 0, 0);
        d.typed = 1;
        d.est = '{20'd0, 15'd0, 24'd0, 1'b1};
        tab.insert(tab.size(), d);
        tab.insert(tab.size(), row(OP_OPEN, 0, 0, 0, 0, 0, 0, 10));
        tab.insert(tab.size(), row(OP_OPEN, 0, 0, 0, 0, 0, 5000, 20));
        tab.insert(tab.size(), row(OP_EVAL, 1000, 1000, 10, 10, 100, 0, 60));
        tab.insert(tab.size(), row(OP_EVAL, 1000, -1000, 10, 10, 100, 0, 100));
        tab.insert(tab.size(), row(OP_EVAL, -1000, -1000, 10, 10, 100, 0, 140));
        tab.insert(tab.size(), row(OP_EVAL, -1000, 1000, 10, 10, 100, 0, 180));
        tab.insert(tab.size(), row(OP_EVAL, 0, -2000, 10, 10, 100, 0, 220));
        tab.insert(tab.size(), row(OP_EVAL, -524288, -524288, 0, 0, 4095, 0, 221));
        tab.insert(tab.size(), row(OP_EVAL, 524287, 524287, 0, 0, 4095, 0, 222));
        tab.insert(tab.size(), row(OP_EVAL, 0, 0, 0, 0, 4095, 0, 223));
        // same timestamp
        tab.insert(tab.size(), row(OP_EVAL, 600, 0, 0, 0, 4095, 0, 223));
        // time going back
        tab.insert(tab.size(), row(OP_EVAL, 900, 0, 0, 0, 4095, 0, 5));
        // unconfident, moving: holds heading
        tab.insert(tab.size(), row(OP_EVAL, 3000, 10, 'hFFFFFF, 'hFFFFFF, 4095, 0, 50));
        // slow, link heading out of range
        tab.insert(tab.size(), row(OP_EVAL, 10, 10, 'hFFFFFF, 0, 0, 32767, 60));
        tab.insert(tab.size(), row(OP_OPEN, 0, 0, 0, 0, 0, 23040, 'hFFFFFFFFFFFF));
        tab.insert(tab.size(), row(OP_EVAL, 100, 0, 0, 0, 19, 0, 0));
        tab.insert(tab.size(), row(OP_EVAL, 100, 2000, 0, 0, 20, 0, 1));
        tab.insert(tab.size(), row(OP_EVAL, -524288, 0, 0, 0, 20, 0, 2));
        tab.insert(tab.size(), row(OP_EVAL, 0, 0, 0, 0, 20, 23039, 3));
        foreach (tab[i]) send_item(tab[i].itm, tab[i].typed, tab[i].est);

        run_random(280, 0, 0);
        settle_and_write(20'd0, 24'hFFFFFF, 12'd0, 15'd23039);
        run_random(300, 1, 0);
        settle_and_write(20'hFFFFF, 24'd0, 12'hFFF, 15'h7FFF);
        snd_idle = 75;
        rcv_idle = 28;
        run_random(300, 0, 1);
        settle_and_write(20'd1000, 24'd5000, 12'd40, 15'd11520);
        run_random(300, 0, 0);
        settle_and_write(20'd741455, 24'hFFFFFF, 12'hFFF, 15'd0);
        snd_idle = 0;
        rcv_idle = 0;
        run_random(200, 0, 0);
        settle_and_write(20'd300, 24'd700, 12'd15, 15'($urandom_range(0, 23039)));
        run_random(250, 0, 0);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (est_q.size() == 0);
        repeat (200) @(posedge aclk);
        if (errs == 0 && est_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/tshe_pkg.sv
rtl/core/tshe_isqrt.sv
rtl/core/tshe_cordic.sv
rtl/core/tshe_divider.sv
rtl/core/track_speed_heading_estimator.sv
test/tb_track_speed_heading_estimator.sv
